FILE: rtl/set_assoc_cache_lru_prefetch_unit_macros.svh
// Assertion macros for the cache unit.
`ifndef SET_ASSOC_CACHE_LRU_PREFETCH_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_PREFETCH_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SACP_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define SACP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

FILE: rtl/sacp_pkg.sv
// Shared constants, types and helpers of the cache unit.
`default_nettype none
package sacp_pkg;
  // Geometry of the line store; both must be powers of two.
  localparam int unsigned Lines              = 16;
  localparam int unsigned BlockWords         = 4;
  localparam int unsigned AddrWidthDefault   = 16;
  localparam int unsigned MaxPrefetchDefault = 8;
  localparam int unsigned WaysLog2Width      = 3;
  localparam int unsigned DepthWidth         = 4;
  localparam int unsigned CfgIndexWidth      = 1;
  localparam int unsigned CfgDataWidth       = 4;
  localparam int unsigned CountWidth         = 32;
  localparam int unsigned FieldWidth         = 16;

  localparam logic [CfgIndexWidth-1:0] CfgWaysLog2      = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CfgPrefetchDepth = 1'b1;

  // One request item: the word address to read.
  typedef struct packed {
    logic [FieldWidth-1:0] address;
  } sacp_req_t;

  // One result item: hit flag, the word and the two running totals.
  typedef struct packed {
    logic                  hit;
    logic [FieldWidth-1:0] word;
    logic [CountWidth-1:0] hit_count;
    logic [CountWidth-1:0] miss_count;
  } sacp_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch address, bump tick
    logic look;      // search the demand set, decide and write the line
    logic respond;   // load the result register
    logic probe;     // probe one prefetch block and fill if a way is free
  } sacp_cmd_t;

  typedef struct packed {
    logic probes_done;
  } sacp_status_t;
endpackage
`default_nettype wire

FILE: rtl/sacp_stream_if.sv
// Valid/ready stream interface used by both channels.
`default_nettype none
interface sacp_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/sacp_ctrl.sv
// Controller state machine sequencing lookup, response and prefetch probes.
`default_nettype none
module sacp_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire sacp_pkg::sacp_status_t status,
  output sacp_pkg::sacp_cmd_t        cmd
);
  import sacp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_PROBE = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_pending, out_pending_next;

  // The result register empties while probing continues.
  assign out_valid = out_pending;
  assign in_ready  = (state == S_IDLE) && !out_pending;

  always_comb begin
    state_next       = state;
    out_pending_next = out_pending;
    cmd              = '0;
    if (out_pending && out_ready) out_pending_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.start  = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look         = 1'b1;
        cmd.respond      = 1'b1;
        out_pending_next = 1'b1;
        state_next       = S_PROBE;
      end
      S_PROBE: begin
        if (status.probes_done) state_next = S_WAIT;
        else cmd.probe = 1'b1;
      end
      S_WAIT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_pending <= 1'b0;
    end else begin
      state       <= state_next;
      out_pending <= out_pending_next;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sacp_datapath.sv
// Tag and timestamp stores with lookup, victim choice and prefetch.
`default_nettype none
module sacp_datapath #(
  parameter int unsigned ADDR_WIDTH   = sacp_pkg::AddrWidthDefault,
  parameter int unsigned MAX_PREFETCH = sacp_pkg::MaxPrefetchDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire sacp_pkg::sacp_cmd_t                 cmd,
  output sacp_pkg::sacp_status_t                   status,
  input  wire logic [sacp_pkg::WaysLog2Width-1:0]  ways_log2,
  input  wire logic [sacp_pkg::DepthWidth-1:0]     prefetch_depth,
  input  wire logic [ADDR_WIDTH-1:0]               address,
  output logic                                     hit,
  output logic [sacp_pkg::FieldWidth-1:0]          word,
  output logic [sacp_pkg::CountWidth-1:0]          hit_count,
  output logic [sacp_pkg::CountWidth-1:0]          miss_count
);
  import sacp_pkg::*;

  localparam int unsigned LineW = $clog2(Lines);
  localparam int unsigned OffB  = $clog2(BlockWords);
  localparam int unsigned KMax  = $clog2(Lines + 1) - 1; // largest k with 2^k <= Lines
  localparam int unsigned BlkW  = ADDR_WIDTH - OffB;
  localparam int unsigned PfW   = $clog2(MAX_PREFETCH + 1);

  logic [BlkW-1:0]       tags [Lines];
  logic [Lines-1:0]      valid;
  logic [CountWidth-1:0] last_use [Lines];

  logic [CountWidth-1:0] tick;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [BlkW-1:0]       pf_blk;
  logic [PfW-1:0]        pf_count;

  // Effective associativity and depth.
  logic [WaysLog2Width-1:0] k_eff;
  logic [PfW-1:0]           depth_eff;
  assign k_eff = (32'(ways_log2) > KMax) ? WaysLog2Width'(KMax) : ways_log2;
  assign depth_eff = (32'(prefetch_depth) > MAX_PREFETCH) ?
                     PfW'(MAX_PREFETCH) : PfW'(prefetch_depth);
  assign status.probes_done = (pf_count >= depth_eff);

  // Block under examination: demand block in LOOK, prefetch block in PROBE.
  logic [BlkW-1:0]  cur_blk;
  logic [LineW-1:0] set_mask, way_mask;
  logic [LineW-1:0] set_base;
  logic [BlkW-1:0]  cur_tag;
  assign cur_blk  = cmd.probe ? pf_blk : addr_q[ADDR_WIDTH-1:OffB];
  assign way_mask = LineW'((32'd1 << k_eff) - 32'd1);
  assign set_mask = LineW'((Lines >> k_eff) - 32'd1);
  assign set_base = LineW'((cur_blk[LineW-1:0] & set_mask) << k_eff);
  // The tag is the block number above the set index bits, log2 of the set count.
  assign cur_tag  = BlkW'(cur_blk >> (LineW - 32'(k_eff)));

  // Per-line match within the selected set; lines are independent lanes.
  logic [Lines-1:0] in_set, match, free;
  always_comb begin
    for (int l = 0; l < Lines; l++) begin
      in_set[l] = ((LineW'(l) & ~way_mask) == set_base);
      match[l]  = in_set[l] && valid[l] && (tags[l] == cur_tag);
      free[l]   = in_set[l] && !valid[l];
    end
  end

  logic             any_match, any_free;
  logic [LineW-1:0] match_line, free_line, lru_line;
  assign any_match = |match;
  assign any_free  = |free;

  // Oldest timestamp in the set found by a tree of pairwise compares; the
  // lower half wins unless the upper one is strictly older, so the lowest
  // line wins a tie.
  logic [LineW-1:0]      lru_node_line  [2*Lines];
  logic [CountWidth-1:0] lru_node_stamp [2*Lines];
  logic                  lru_node_ok    [2*Lines];

  always_comb begin
    match_line = '0;
    free_line  = '0;
    for (int l = Lines - 1; l >= 0; l--) begin
      if (match[l]) match_line = LineW'(l);
      if (free[l]) free_line = LineW'(l);
    end
    lru_node_line[0]  = '0;
    lru_node_stamp[0] = '0;
    lru_node_ok[0]    = 1'b0;
    for (int l = 0; l < Lines; l++) begin
      lru_node_line[Lines + l]  = LineW'(l);
      lru_node_stamp[Lines + l] = last_use[l];
      lru_node_ok[Lines + l]    = in_set[l];
    end
    for (int n = Lines - 1; n >= 1; n--) begin
      if (lru_node_ok[2*n+1] &&
          (!lru_node_ok[2*n] || (lru_node_stamp[2*n+1] < lru_node_stamp[2*n]))) begin
        lru_node_line[n]  = lru_node_line[2*n+1];
        lru_node_stamp[n] = lru_node_stamp[2*n+1];
      end else begin
        lru_node_line[n]  = lru_node_line[2*n];
        lru_node_stamp[n] = lru_node_stamp[2*n];
      end
      lru_node_ok[n] = lru_node_ok[2*n] || lru_node_ok[2*n+1];
    end
    lru_line = lru_node_line[1];
  end

  logic [LineW-1:0] victim;
  assign victim = any_free ? free_line : lru_line;

  logic             do_fill;
  logic [LineW-1:0] fill_line;
  assign do_fill   = (cmd.look && !any_match) || (cmd.probe && !any_match && any_free);
  assign fill_line = cmd.look ? victim : free_line;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      tick       <= '0;
      hit_count  <= '0;
      miss_count <= '0;
      pf_count   <= '0;
    end else begin
      if (cmd.start) begin
        tick     <= tick + 1'b1;
        pf_count <= '0;
      end
      if (cmd.look) begin
        if (any_match) begin
          if (hit_count != '1) hit_count <= hit_count + 1'b1;
        end else if (miss_count != '1) begin
          miss_count <= miss_count + 1'b1;
        end
      end
      if (cmd.probe) pf_count <= pf_count + 1'b1;
      if (do_fill) valid[fill_line] <= 1'b1;
    end
  end

  // Payload stores.
  always_ff @(posedge clk) begin
    if (cmd.start) addr_q <= address;
    if (cmd.look) begin
      pf_blk <= addr_q[ADDR_WIDTH-1:OffB] + 1'b1;
      if (any_match) last_use[match_line] <= tick;
    end
    if (cmd.probe) pf_blk <= pf_blk + 1'b1;
    if (do_fill) begin
      tags[fill_line]     <= cur_tag;
      last_use[fill_line] <= tick;
    end
  end

  // A present or freshly filled block holds its own word addresses, so the
  // word read back is the demand address itself.
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      hit  <= any_match;
      word <= FieldWidth'(addr_q);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/set_assoc_cache_lru_prefetch_unit.sv
// Top level of the set-associative cache with LRU and next-block prefetch.
`default_nettype none
// Read-only cache of Lines lines of BlockWords words (package constants).
// Each accepted address item gives one result item: hit flag, the word at that
// address, and saturating hit and miss totals. The controller steps one tag
// search of the set per cycle: the lookup, then prefetch probes up to the
// depth (at most MAX_PREFETCH), then a wait state. The result register is
// released while probes run, so the result may be taken early; a new item is
// only accepted once the previous result has been taken. Reset clears valid
// bits, counters, settings and control state, not the tag and time stores.
module set_assoc_cache_lru_prefetch_unit #(
  parameter int unsigned ADDR_WIDTH   = sacp_pkg::AddrWidthDefault,
  parameter int unsigned MAX_PREFETCH = sacp_pkg::MaxPrefetchDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [sacp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [sacp_pkg::CfgDataWidth-1:0]  cfg_data,
  sacp_stream_if.sink                            req,
  sacp_stream_if.source                          rsp
);
  import sacp_pkg::*;
  `include "set_assoc_cache_lru_prefetch_unit_macros.svh"

  logic [WaysLog2Width-1:0] ways_log2;
  logic [DepthWidth-1:0]    prefetch_depth;
  sacp_cmd_t                cmd;
  sacp_status_t             status;
  logic                     rsp_hit;
  logic [FieldWidth-1:0]    rsp_word;
  logic [CountWidth-1:0]    rsp_hit_count;
  logic [CountWidth-1:0]    rsp_miss_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2      <= '0;
      prefetch_depth <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgWaysLog2:      ways_log2      <= cfg_data[WaysLog2Width-1:0];
        CfgPrefetchDepth: prefetch_depth <= cfg_data;
        default: ;
      endcase
    end
  end

  sacp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .status, .cmd
  );

  sacp_datapath #(
    .ADDR_WIDTH(ADDR_WIDTH), .MAX_PREFETCH(MAX_PREFETCH)
  ) u_dp (
    .clk, .rst, .cmd, .status, .ways_log2, .prefetch_depth,
    .address(ADDR_WIDTH'(req.payload.address)),
    .hit(rsp_hit), .word(rsp_word),
    .hit_count(rsp_hit_count), .miss_count(rsp_miss_count)
  );

  assign rsp.payload = {rsp_hit, rsp_word, rsp_hit_count, rsp_miss_count};

  // No new item while a result is still held.
  `SACP_ASSERT_IMPL(a_no_accept_pending, clk, rst, rsp.valid, !req.ready, "accept while pending")
  // An accepted item is looked up on the next cycle.
  `SACP_ASSERT_NEXT(a_start_look, clk, rst, req.valid && req.ready, cmd.look, "no lookup")
  // Probing never runs alongside a lookup.
  `SACP_ASSERT_IMPL(a_excl, clk, rst, cmd.probe, !cmd.look && !cmd.start, "overlap")
endmodule
`default_nettype wire
